/* hw/rtl/ccl_pkg.sv */
// Shared types and constants for the command file chunk parser.
package ccl_pkg;

    localparam logic [7:0] TYPE_LOAD = 8'h01;
    localparam logic [7:0] TYPE_XFER = 8'h02;
    localparam logic [7:0] TYPE_HDR  = 8'h05;

    typedef enum logic [2:0] {
        PH_TYPE = 3'd0,
        PH_LEN  = 3'd1,
        PH_ALO  = 3'd2,
        PH_AHI  = 3'd3,
        PH_DATA = 3'd4,
        PH_SKIP = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_LOAD = 2'd1,
        KIND_XFER = 2'd2,
        KIND_HDR  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        EVK_WRITE   = 3'd0,
        EVK_JUMP    = 3'd1,
        EVK_RUNOFF  = 3'd2,
        EVK_UNKNOWN = 3'd3,
        EVK_TRUNC   = 3'd4
    } evk_t;

    typedef struct packed {
        evk_t        kind;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        last;
    } ccl_event_t;

    typedef struct packed {
        logic [1:0] count;
        ccl_event_t first;
        ccl_event_t second;
    } ccl_step_t;

endpackage

/* hw/rtl/ccl_parser.sv */
// Chunk parser state and the events that one file byte produces.
module ccl_parser
    import ccl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] file_byte,
    input  logic       final_byte,
    output ccl_step_t  result
);

    phase_t      phase_reg, phase_next;
    kind_t       kind_reg, kind_next;
    logic [8:0]  left_reg, left_next;
    logic [15:0] addr_reg, addr_next;
    logic        stopped_reg, stopped_next;

    logic        main_v;
    ccl_event_t  main_ev;
    logic        fin_v;
    ccl_event_t  fin_ev;
    logic [8:0]  left_dec;
    logic [8:0]  left_dec2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TYPE;
            kind_reg    <= KIND_NONE;
            left_reg    <= 9'd0;
            addr_reg    <= 16'd0;
            stopped_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            kind_reg    <= kind_next;
            left_reg    <= left_next;
            addr_reg    <= addr_next;
            stopped_reg <= stopped_next;
        end
    end

    always_comb
    begin
        left_dec     = left_reg - 9'd1;
        left_dec2    = left_reg - 9'd2;
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        left_next    = left_reg;
        addr_next    = addr_reg;
        stopped_next = stopped_reg;
        main_v       = 1'b0;
        main_ev      = '{kind: EVK_WRITE, addr: 16'd0, data: 8'd0, last: 1'b0};

        if (!stopped_reg)
        begin
            unique case (phase_reg)
                PH_TYPE:
                begin
                    unique case (file_byte)
                        TYPE_LOAD:
                        begin
                            kind_next  = KIND_LOAD;
                            phase_next = PH_LEN;
                        end
                        TYPE_XFER:
                        begin
                            kind_next  = KIND_XFER;
                            phase_next = PH_LEN;
                        end
                        TYPE_HDR:
                        begin
                            kind_next  = KIND_HDR;
                            phase_next = PH_LEN;
                        end
                        default:
                        begin
                            kind_next    = KIND_NONE;
                            main_v       = 1'b1;
                            main_ev.kind = EVK_UNKNOWN;
                            stopped_next = 1'b1;
                        end
                    endcase
                end
                PH_LEN:
                begin
                    unique case (kind_reg)
                        KIND_LOAD:
                        begin
                            // Load lengths of 0 to 2 wrap round: 256 is added to them.
                            left_next  = {(file_byte <= 8'd2), file_byte};
                            phase_next = PH_ALO;
                        end
                        KIND_HDR:
                        begin
                            left_next  = (file_byte == 8'd0) ? 9'd256 : {1'b0, file_byte};
                            phase_next = PH_SKIP;
                        end
                        default:
                        begin
                            left_next  = {1'b0, file_byte};
                            phase_next = PH_ALO;
                        end
                    endcase
                end
                PH_ALO:
                begin
                    addr_next  = {8'd0, file_byte};
                    phase_next = PH_AHI;
                end
                PH_AHI:
                begin
                    addr_next = {file_byte, addr_reg[7:0]};
                    if (kind_reg == KIND_LOAD)
                    begin
                        left_next  = left_dec2;
                        phase_next = (left_dec2 == 9'd0) ? PH_TYPE : PH_DATA;
                    end
                    else
                    begin
                        main_v       = 1'b1;
                        main_ev.kind = EVK_JUMP;
                        main_ev.addr = {file_byte, addr_reg[7:0]};
                        stopped_next = 1'b1;
                        phase_next   = PH_TYPE;
                    end
                end
                PH_DATA:
                begin
                    main_v       = 1'b1;
                    main_ev.addr = addr_reg;
                    main_ev.data = file_byte;
                    addr_next    = addr_reg + 16'd1;
                    left_next    = left_dec;
                    if (left_dec == 9'd0)
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_SKIP:
                begin
                    left_next = left_dec;
                    if (left_dec == 9'd0)
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                default:
                begin
                    phase_next = PH_TYPE;
                end
            endcase
        end

        fin_v       = final_byte && !stopped_next;
        fin_ev      = '{kind: EVK_RUNOFF, addr: 16'd0, data: 8'd0, last: 1'b1};
        if (phase_next != PH_TYPE)
        begin
            fin_ev.kind = EVK_TRUNC;
        end

        // The last byte of a file returns the parser to its reset state.
        if (final_byte)
        begin
            phase_next   = PH_TYPE;
            kind_next    = KIND_NONE;
            left_next    = 9'd0;
            addr_next    = 16'd0;
            stopped_next = 1'b0;
        end

        main_ev.last  = !fin_v;
        result.count  = {1'b0, main_v} + {1'b0, fin_v};
        result.first  = main_v ? main_ev : fin_ev;
        result.second = fin_ev;
    end

endmodule

/* hw/rtl/cmd_chunk_loader_parser_core.sv */
// Top level of the command file chunk parser: byte stream in, event stream out.
//
//  channel   dir  tdata                          tuser         tlast
//  s_axis    in   [7:0] file_byte                -             final_byte
//  m_axis    out  [15:0] target_address,         [2:0] kind    last_of_run
//                 [23:16] write_data
//
// One byte is accepted per cycle while s_tready is high; the parser state is
// updated in the same cycle. Both events of a byte that yields two enter the
// queue together. The output takes one event per cycle while m_tready is high,
// and the four-entry event queue absorbs the extra one. s_tready is high while
// the queue has room for two events. Reset clears the parser state and empties
// the queue; a stalled output only holds back input once three events are waiting.
module cmd_chunk_loader_parser_core
    import ccl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] file_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] target_address, [23:16] write_data
    output logic [2:0]  m_tuser,   // [2:0] event_kind
    output logic        m_tlast
);

    logic        s_accept;
    logic        m_accept;
    ccl_step_t   step_res;

    ccl_event_t  queue_reg [4];
    logic [1:0]  wr_reg, rd_reg;
    logic [2:0]  count_reg;
    logic [1:0]  push_n;
    ccl_event_t  head;

    assign s_tready = (count_reg <= 3'd2);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != 3'd0);
    assign m_accept = m_tvalid && m_tready;
    assign push_n   = s_accept ? step_res.count : 2'd0;

    ccl_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s_accept),
        .file_byte  (s_tdata),
        .final_byte (s_tlast),
        .result     (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 2'd0;
            rd_reg    <= 2'd0;
            count_reg <= 3'd0;
        end
        else
        begin
            wr_reg    <= wr_reg + push_n;
            rd_reg    <= rd_reg + {1'b0, m_accept};
            count_reg <= count_reg + {1'b0, push_n} - {2'b00, m_accept};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            queue_reg[wr_reg] <= step_res.first;
        end
        if (push_n == 2'd2)
        begin
            queue_reg[wr_reg + 2'd1] <= step_res.second;
        end
    end

    assign head    = queue_reg[rd_reg];
    assign m_tdata = {head.data, head.addr};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

    property p_queue_bound;
        @(posedge clk) disable iff (!rst_n) count_reg <= 3'd4;
    endproperty
    a_queue_bound: assert property (p_queue_bound)
        else $error("event queue count out of range");

    property p_two_only_at_end;
        @(posedge clk) disable iff (!rst_n)
            (s_accept && step_res.count == 2'd2) |-> s_tlast;
    endproperty
    a_two_only_at_end: assert property (p_two_only_at_end)
        else $error("two events from a byte that is not the last of the file");

    property p_non_write_last;
        @(posedge clk) disable iff (!rst_n)
            (m_tvalid && m_tuser != EVK_WRITE) |-> m_tlast;
    endproperty
    a_non_write_last: assert property (p_non_write_last)
        else $error("jump or error event not marked last of its run");

    property p_error_zero;
        @(posedge clk) disable iff (!rst_n)
            (m_tvalid && (m_tuser == EVK_RUNOFF || m_tuser == EVK_TRUNC
                          || m_tuser == EVK_UNKNOWN)) |-> (m_tdata == 24'd0);
    endproperty
    a_error_zero: assert property (p_error_zero)
        else $error("error event carries address or data");

endmodule
